// File: rtl/core/tfrl_pkg.sv
// Shared types and constants for the timestamped frame ring lookup core.
`default_nettype none
package tfrl_pkg;
    localparam int FRAMES = 64;
    localparam int FRAME_LEN = 150;
    localparam int HALF_BYTES = 75;
    localparam int WORDS = 19;
    localparam logic [20:0] FAR_START = 21'd1000000;
    localparam logic [20:0] MATCH_LIMIT = 21'd400;
    localparam logic [20:0] NEAR_ENOUGH = 21'd6;
    localparam logic [7:0] MARK_VALUE = 8'd15;
    localparam logic [15:0] PHASE_STEP = 16'd1043;

    localparam logic [1:0] SRC_FRAME = 2'd0;
    localparam logic [1:0] SRC_PATTERN = 2'd1;
    localparam logic [1:0] SRC_NONE = 2'd2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [3:0] {
        t_S_IDLE, t_S_SCAN_RD, t_S_SCAN_CMP, t_S_DECIDE,
        t_S_PAT, t_S_FRM_RD, t_S_FRM_WAIT, t_S_FRM_BYTE, t_S_OUT, t_S_NONE
    } t_state;

    typedef struct packed {
        logic scan_init;
        logic scan_rd;
        logic scan_cmp;
        logic word_init;
        logic byte_rd;
        logic byte_take;
        logic pat_byte;
        logic word_next;
        logic commit_hit;
        logic commit_pat;
        logic use_pattern;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic scan_done;
        logic hit;
        logic none;
        logic byte_last;
        logic word_last;
    } t_status;

    // quarter-wave threshold sine, signed byte
    function automatic logic [7:0] sine_byte(input logic [15:0] p);
        logic [1:0] q;
        logic [13:0] r;
        logic [14:0] a;
        logic [2:0] k;
        q = p[15:14];
        r = p[13:0];
        a = q[0] ? (15'd16384 - {1'b0, r}) : {1'b0, r};
        k = 3'(a >= 15'd1496) + 3'(a >= 15'd3023) + 3'(a >= 15'd4620)
          + 3'(a >= 15'd6345) + 3'(a >= 15'd8299) + 3'(a >= 15'd10741)
          + 3'(a >= 15'd16384);
        sine_byte = q[1] ? (8'd0 - {5'd0, k}) : {5'd0, k};
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/tfrl_ram.sv
// Generic RAM with one write port, one read port and registered read.
`default_nettype none
module tfrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/tfrl_ctrl.sv
// Controller state machine sequencing search and word output of a get.
`default_nettype none
module tfrl_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_get,
    input  wire                    i_single,
    input  wire                    i_disabled,
    input  wire                    i_pattern,
    input  wire                    i_out_stall,
    input  wire tfrl_pkg::t_status i_status,
    output tfrl_pkg::t_cmd         o_cmd,
    output logic                   o_busy,
    output logic                   o_out_valid,
    output logic                   o_none
);
    tfrl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfrl_pkg::t_S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = 1'b1;
        o_out_valid = 1'b0;
        o_none = 1'b0;
        unique case (r_state)
            tfrl_pkg::t_S_IDLE: begin
                o_busy = i_status.clearing;
                if (i_get) begin
                    if (i_disabled) begin
                        n_state = tfrl_pkg::t_S_NONE;
                    end else if (i_single) begin
                        o_cmd.word_init = 1'b1;
                        n_state = tfrl_pkg::t_S_FRM_RD;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = tfrl_pkg::t_S_SCAN_RD;
                    end
                end
            end
            tfrl_pkg::t_S_SCAN_RD: begin
                if (i_status.scan_done) begin
                    n_state = tfrl_pkg::t_S_DECIDE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = tfrl_pkg::t_S_SCAN_CMP;
                end
            end
            tfrl_pkg::t_S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = tfrl_pkg::t_S_SCAN_RD;
            end
            tfrl_pkg::t_S_DECIDE: begin
                o_cmd.word_init = 1'b1;
                if (i_status.hit) begin
                    o_cmd.commit_hit = 1'b1;
                    n_state = tfrl_pkg::t_S_FRM_RD;
                end else if (i_status.none) begin
                    n_state = tfrl_pkg::t_S_NONE;
                end else begin
                    o_cmd.use_pattern = 1'b1;
                    n_state = tfrl_pkg::t_S_PAT;
                end
            end
            tfrl_pkg::t_S_PAT: begin
                o_cmd.pat_byte = 1'b1;
                if (i_status.byte_last) begin
                    n_state = tfrl_pkg::t_S_OUT;
                end
            end
            tfrl_pkg::t_S_FRM_RD: begin
                o_cmd.byte_rd = 1'b1;
                n_state = tfrl_pkg::t_S_FRM_WAIT;
            end
            tfrl_pkg::t_S_FRM_WAIT: begin
                n_state = tfrl_pkg::t_S_FRM_BYTE;
            end
            tfrl_pkg::t_S_FRM_BYTE: begin
                o_cmd.byte_take = 1'b1;
                n_state = i_status.byte_last ? tfrl_pkg::t_S_OUT : tfrl_pkg::t_S_FRM_RD;
            end
            tfrl_pkg::t_S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.word_next = 1'b1;
                    if (i_status.word_last) begin
                        o_cmd.commit_pat = 1'b1;
                        n_state = tfrl_pkg::t_S_IDLE;
                    end else begin
                        n_state = i_pattern ? tfrl_pkg::t_S_PAT : tfrl_pkg::t_S_FRM_RD;
                    end
                end
            end
            tfrl_pkg::t_S_NONE: begin
                o_out_valid = 1'b1;
                o_none = 1'b1;
                if (!i_out_stall) begin
                    n_state = tfrl_pkg::t_S_IDLE;
                end
            end
            default: n_state = tfrl_pkg::t_S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/tfrl_dp.sv
// Datapath: frame storage, timestamp search, word assembly, fallback pattern.
`default_nettype none
module tfrl_dp (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [6:0]              i_cfg_data,
    input  wire                    i_add,
    input  wire                    i_get,
    input  wire [31:0]             i_timestamp,
    input  wire [1:0]              i_channel_mask,
    input  wire                    i_force_both,
    input  wire [7:0]              i_byte_index,
    input  wire [7:0]              i_byte_value,
    input  wire                    i_frame_end,
    input  tfrl_pkg::t_cmd         i_cmd,
    output tfrl_pkg::t_status      o_status,
    output logic                   o_single,
    output logic                   o_disabled,
    output logic [6:0]             o_frame_count,
    output logic                   o_pattern,
    output logic [63:0]            o_word,
    output logic [4:0]             o_word_index
);
    localparam int SW = (tfrl_pkg::FRAMES > 1) ? $clog2(tfrl_pkg::FRAMES) : 1;
    localparam int BW = $clog2(tfrl_pkg::FRAMES * tfrl_pkg::FRAME_LEN);
    localparam logic [6:0] FMAX = 7'(tfrl_pkg::FRAMES);

    logic [6:0]  r_count;
    logic [SW-1:0] r_wslot, r_start, r_i, r_best;
    logic [1:0]  r_best_chan;
    logic [6:0]  r_visit;
    logic        r_have_best, r_done;
    logic [20:0] r_closest;
    logic [31:0] r_want;
    logic [1:0]  r_mask;
    logic [7:0]  r_marker;
    logic [15:0] r_phase, r_ph_cur;
    logic        r_pat;
    logic [SW-1:0] r_fslot;
    logic [4:0]  r_word;
    logic [2:0]  r_b;
    logic [63:0] r_data;
    logic        r_clearing;
    logic [BW-1:0] r_clr;

    logic [SW-1:0] slot;
    logic [1:0]  amask;
    logic        half_ok;
    logic        bwe, twe;
    logic [BW-1:0] bwaddr, braddr;
    logic [7:0]  brdata;
    logic [33:0] trd;
    logic [31:0] trdata;
    logic [1:0]  tchan;
    logic [32:0] diff, adiff;
    logic [20:0] dsat;
    logic        dbig;
    logic [7:0]  pos;
    logic [7:0]  pbyte, mpos;
    logic [SW-1:0] inext;

    assign o_single = (r_count == 7'd1);
    assign o_disabled = (r_count == 7'd0);
    assign o_frame_count = r_count;
    assign o_pattern = r_pat;
    assign o_word = r_data;
    assign o_word_index = r_word;

    assign slot = (o_single || 7'(r_wslot) >= r_count) ? '0 : r_wslot;
    always_comb begin
        amask = i_channel_mask;
        if (amask == 2'b11 && !i_force_both) begin
            amask = 2'b01;
        end
    end
    assign half_ok = (i_byte_index >= 8'(tfrl_pkg::HALF_BYTES)) ? amask[1] : amask[0];
    assign bwe = i_add && !o_disabled && i_byte_index < 8'(tfrl_pkg::FRAME_LEN);
    assign twe = i_add && !o_disabled && i_frame_end;
    assign bwaddr = BW'(slot * tfrl_pkg::FRAME_LEN) + BW'(i_byte_index);
    assign pos = {r_word, r_b};
    assign braddr = BW'(r_fslot * tfrl_pkg::FRAME_LEN) + BW'(pos);

    tfrl_ram #(.WIDTH(8), .DEPTH(tfrl_pkg::FRAMES * tfrl_pkg::FRAME_LEN)) u_bytes (
        .i_clk(i_clk), .i_we(r_clearing || bwe),
        .i_waddr(r_clearing ? r_clr : bwaddr),
        .i_wdata((r_clearing || !half_ok) ? 8'd0 : i_byte_value),
        .i_raddr(braddr), .o_rdata(brdata)
    );
    // timestamp in the low bits, committed channel mask on top
    tfrl_ram #(.WIDTH(34), .DEPTH(tfrl_pkg::FRAMES)) u_time (
        .i_clk(i_clk),
        .i_we(r_clearing ? (r_clr < BW'(tfrl_pkg::FRAMES)) : twe),
        .i_waddr(r_clearing ? r_clr[SW-1:0] : slot),
        .i_wdata(r_clearing ? 34'd0 : {amask, i_timestamp}),
        .i_raddr(r_i), .o_rdata(trd)
    );
    assign trdata = trd[31:0];
    assign tchan = trd[33:32];

    assign diff = {r_want[31], r_want} - {trdata[31], trdata};
    assign adiff = diff[32] ? (33'd0 - diff) : diff;
    assign dbig = |adiff[32:21];
    assign dsat = dbig ? '1 : adiff[20:0];
    assign inext = (7'(r_i) + 7'd1 >= r_count) ? '0 : SW'(7'(r_i) + 7'd1);

    always_comb begin
        mpos = (r_marker >= 8'(tfrl_pkg::HALF_BYTES))
             ? 8'(tfrl_pkg::FRAME_LEN - 1) - r_marker : r_marker;
        if (pos < 8'(tfrl_pkg::HALF_BYTES)) begin
            pbyte = (pos == mpos) ? tfrl_pkg::MARK_VALUE : 8'd0;
        end else if (pos < 8'(tfrl_pkg::FRAME_LEN)) begin
            pbyte = tfrl_pkg::sine_byte(r_ph_cur);
        end else begin
            pbyte = 8'd0;
        end
    end

    assign o_status.clearing = r_clearing;
    assign o_status.scan_done = r_done;
    assign o_status.hit = r_have_best && (r_best_chan & r_mask) != 2'b00
                          && r_closest < tfrl_pkg::MATCH_LIMIT;
    assign o_status.none = r_have_best && (r_best_chan & r_mask) != 2'b00
                           && r_closest == tfrl_pkg::MATCH_LIMIT;
    assign o_status.byte_last = (r_b == 3'd7);
    assign o_status.word_last = (r_word == 5'(tfrl_pkg::WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wslot <= '0;
            r_start <= '0;
            r_marker <= '0;
            r_phase <= '0;
            r_pat <= 1'b0;
            r_clearing <= 1'b1;
            r_clr <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + BW'(1);
                if (r_clr == BW'(tfrl_pkg::FRAMES * tfrl_pkg::FRAME_LEN - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_count <= (i_cfg_data > FMAX) ? FMAX : i_cfg_data;
                r_wslot <= '0;
                r_start <= '0;
            end
            if (twe) begin
                r_wslot <= (7'(slot) + 7'd1 >= r_count) ? '0 : SW'(7'(slot) + 7'd1);
            end
            if (i_get) begin
                r_pat <= 1'b0;
            end
            if (i_cmd.use_pattern) begin
                r_pat <= 1'b1;
            end
            if (i_cmd.commit_hit) begin
                r_start <= r_best;
                r_marker <= '0;
                r_phase <= '0;
            end
            if (i_cmd.commit_pat && r_pat) begin
                r_marker <= (r_marker >= 8'(tfrl_pkg::FRAME_LEN - 1)) ? 8'd0 : r_marker + 8'd1;
                r_phase <= r_phase + tfrl_pkg::PHASE_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_get) begin
            r_want <= i_timestamp;
            r_mask <= i_channel_mask;
        end
        if (i_cmd.scan_init) begin
            r_i <= (7'(r_start) >= r_count) ? '0 : r_start;
            r_visit <= '0;
            r_closest <= tfrl_pkg::FAR_START;
            r_have_best <= 1'b0;
            r_done <= 1'b0;
        end
        if (i_cmd.scan_cmp) begin
            if (!dbig && dsat < r_closest) begin
                r_closest <= dsat;
                r_best <= r_i;
                r_best_chan <= tchan;
                r_have_best <= 1'b1;
                r_done <= (r_visit + 7'd1 >= r_count);
            end else if (r_closest <= tfrl_pkg::NEAR_ENOUGH) begin
                r_done <= 1'b1;
            end else begin
                r_done <= (r_visit + 7'd1 >= r_count);
            end
            r_visit <= r_visit + 7'd1;
            r_i <= inext;
        end
        if (i_cmd.word_init) begin
            r_word <= '0;
            r_b <= '0;
            r_data <= '0;
            r_ph_cur <= r_phase;
            r_fslot <= (i_cmd.commit_hit) ? r_best : '0;
        end
        if (i_cmd.byte_take) begin
            r_data[8*r_b +: 8] <= (pos < 8'(tfrl_pkg::FRAME_LEN)) ? brdata : 8'd0;
            r_b <= r_b + 3'd1;
        end
        if (i_cmd.pat_byte) begin
            r_data[8*r_b +: 8] <= pbyte;
            r_b <= r_b + 3'd1;
            if (pos >= 8'(tfrl_pkg::HALF_BYTES) && pos < 8'(tfrl_pkg::FRAME_LEN)) begin
                r_ph_cur <= r_ph_cur + tfrl_pkg::PHASE_STEP;
            end
        end
        if (i_cmd.word_next) begin
            r_word <= r_word + 5'd1;
            r_b <= '0;
            r_data <= '0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/timestamped_frame_ring_lookup_core.sv
// Top level of the timestamped frame ring lookup core.
// After reset a clearing pass zeroes the frame and timestamp stores; input
// is stalled until it ends. An add item does not stall the input. With two
// or more frames a get scans up to frame_count timestamps, a read state and
// a compare state per slot (registered read of the timestamp memory), then
// sees the end of the walk and takes a decision state; it then builds 19
// output words, each ended by the output state: from a stored frame every
// byte passes read, wait and take states, for the fallback pattern one pattern
// state. Input is stalled while a get is in flight, output stall included.
`default_nettype none
module timestamped_frame_ring_lookup_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [0:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [0:0]  i_opcode,
    input  wire  [31:0] i_timestamp,
    input  wire  [1:0]  i_channel_mask,
    input  wire  [0:0]  i_force_both,
    input  wire  [7:0]  i_byte_index,
    input  wire  [7:0]  i_byte_value,
    input  wire  [0:0]  i_frame_end,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_data_word,
    output logic [4:0]  o_word_index,
    output logic [1:0]  o_source,
    output logic        o_is_last
);
    tfrl_pkg::t_cmd    cmd;
    tfrl_pkg::t_status status;
    logic busy, single, disabled, pattern, none, acc;
    logic [6:0] fc;
    logic [63:0] word;
    logic [4:0] widx;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {25'd0, fc} : 32'd0;
    assign o_stall = busy;
    assign acc = i_valid && !busy;

    tfrl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(psel && penable && pwrite && paddr == 1'b0),
        .i_cfg_data(pwdata[6:0]),
        .i_add(acc && i_opcode == tfrl_pkg::OP_ADD),
        .i_get(acc && i_opcode == tfrl_pkg::OP_GET),
        .i_timestamp(i_timestamp), .i_channel_mask(i_channel_mask),
        .i_force_both(i_force_both[0]), .i_byte_index(i_byte_index),
        .i_byte_value(i_byte_value), .i_frame_end(i_frame_end[0]),
        .i_cmd(cmd), .o_status(status), .o_single(single), .o_disabled(disabled),
        .o_frame_count(fc), .o_pattern(pattern), .o_word(word), .o_word_index(widx)
    );

    tfrl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_get(acc && i_opcode == tfrl_pkg::OP_GET),
        .i_single(single), .i_disabled(disabled), .i_pattern(pattern),
        .i_out_stall(i_stall),
        .i_status(status), .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_valid),
        .o_none(none)
    );

    assign o_data_word = none ? 64'd0 : word;
    assign o_word_index = none ? 5'd0 : widx;
    assign o_source = none ? tfrl_pkg::SRC_NONE
                    : (pattern ? tfrl_pkg::SRC_PATTERN : tfrl_pkg::SRC_FRAME);
    assign o_is_last = none || status.word_last;
endmodule
`default_nettype wire
